// ===== rtl/ovl_pkg.sv =====
package ovl_pkg;

    localparam int CAPACITY = 64;
    localparam int VAL_W    = 32;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        CMD_APPEND    = 2'd0,
        CMD_REMOVE    = 2'd1,
        CMD_LIST_ALL  = 2'd2,
        CMD_LIST_EVEN = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        STS_ENTRY     = 3'd0,
        STS_REMOVED   = 3'd1,
        STS_NOT_FOUND = 3'd2,
        STS_EMPTY     = 3'd3,
        STS_FULL      = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_ROTATE,
        CELL_DROP
    } t_cell_op;

    typedef struct packed {
        logic [1:0]              command;
        logic signed [VAL_W-1:0] operand_value;
    } t_in_word;

    typedef struct packed {
        logic [2:0]              status;
        logic signed [VAL_W-1:0] entry_value;
        logic                    last;
    } t_out_word;

    typedef struct packed {
        t_cell_op                op;
        logic [IDX_W-1:0]        tail_idx;
        logic [IDX_W-1:0]        slot_idx;
        logic signed [VAL_W-1:0] load_value;
    } t_cell_ctrl;

endpackage

// ===== rtl/ovl_cell.sv =====
module ovl_cell (
    input  logic                             i_clk,
    input  ovl_pkg::t_cell_ctrl              i_ctrl,
    input  logic [ovl_pkg::IDX_W-1:0]        i_index,
    input  logic signed [ovl_pkg::VAL_W-1:0] i_next_value,
    input  logic signed [ovl_pkg::VAL_W-1:0] i_head_value,
    output logic signed [ovl_pkg::VAL_W-1:0] o_value
);
    import ovl_pkg::*;

    logic signed [VAL_W-1:0] r_value;
    logic signed [VAL_W-1:0] n_value;

    always_comb begin
        n_value = r_value;
        case (i_ctrl.op)
            CELL_LOAD: begin
                if (i_index == i_ctrl.slot_idx) begin
                    n_value = i_ctrl.load_value;
                end
            end
            // the tail cell closes the ring by taking the head
            CELL_ROTATE: begin
                n_value = (i_index == i_ctrl.tail_idx) ? i_head_value : i_next_value;
            end
            CELL_DROP: n_value = i_next_value;
            default:   n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

// ===== rtl/ordered_value_list_unit.sv =====
// ordered list of signed 32-bit values, up to CAPACITY entries, held in a row of
// cells with the head in cell 0. append gives no word unless the list is full.
// remove, list all and list even each walk the list once by rotating the ring
// of occupied cells one place per cycle while the output is free, head out to
// the tail: the command is accepted, the walk takes one step per stored entry,
// then a finish state follows; a stalled output stretches the walk. each
// picked entry is held until the next pick or the finish cycle before it leaves,
// so at most one list word leaves per walk cycle and the final word can carry
// last. a command on an empty list gives one empty word.
module ordered_value_list_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ovl_pkg::t_in_word i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output ovl_pkg::t_out_word o_out_word
);
    import ovl_pkg::*;

    // control
    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [CNT_W-1:0]        r_left, n_left;
    t_cmd                    r_cmd, n_cmd;
    logic signed [VAL_W-1:0] r_val, n_val;
    logic                    r_found, n_found;
    logic                    r_pend_v, n_pend_v;
    logic signed [VAL_W-1:0] r_pend, n_pend;

    // output register
    logic                    r_out_valid, n_out_valid;
    t_out_word               r_out, n_out;

    // cell row
    t_cell_ctrl              cell_ctrl;
    logic signed [VAL_W-1:0] cell_value [CAPACITY];

    logic                    out_free;
    logic                    in_fire;
    logic                    emit;
    logic [CNT_W-1:0]        tail_cnt;
    logic signed [VAL_W-1:0] head;
    logic                    head_pick;
    logic                    is_full;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && out_free;
    assign in_fire    = i_in_valid && o_in_ready;
    assign tail_cnt   = r_count - CNT_W'(1);
    assign head       = cell_value[0];
    // list all takes every head, list even only those with a clear low bit
    assign head_pick  = (r_cmd == CMD_LIST_ALL) || !head[0];
    assign is_full    = (r_count >= CNT_W'(CAPACITY));

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic signed [VAL_W-1:0] next_value;
            if (g == CAPACITY - 1) begin : g_end
                assign next_value = cell_value[g];
            end else begin : g_mid
                assign next_value = cell_value[g+1];
            end
            ovl_cell u_cell (
                .i_clk        (i_clk),
                .i_ctrl       (cell_ctrl),
                .i_index      (IDX_W'(g)),
                .i_next_value (next_value),
                .i_head_value (head),
                .o_value      (cell_value[g])
            );
        end
    endgenerate

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire && (i_in_word.command != CMD_APPEND) && (r_count != '0)) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (out_free && (r_left == CNT_W'(1))) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_count  = r_count;
        n_left   = r_left;
        n_cmd    = r_cmd;
        n_val    = r_val;
        n_found  = r_found;
        n_pend_v = r_pend_v;
        n_pend   = r_pend;
        emit     = 1'b0;
        n_out    = r_out;

        cell_ctrl.op         = CELL_HOLD;
        cell_ctrl.tail_idx   = tail_cnt[IDX_W-1:0];
        cell_ctrl.slot_idx   = r_count[IDX_W-1:0];
        cell_ctrl.load_value = i_in_word.operand_value;

        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if (i_in_word.command == CMD_APPEND) begin
                        if (is_full) begin
                            emit  = 1'b1;
                            n_out = '{status: STS_FULL, entry_value: '0, last: 1'b1};
                        end else begin
                            cell_ctrl.op = CELL_LOAD;
                            n_count      = r_count + CNT_W'(1);
                        end
                    end else if (r_count == '0) begin
                        emit  = 1'b1;
                        n_out = '{status: STS_EMPTY, entry_value: '0, last: 1'b1};
                    end else begin
                        n_cmd    = t_cmd'(i_in_word.command);
                        n_val    = i_in_word.operand_value;
                        n_left   = r_count;
                        n_found  = 1'b0;
                        n_pend_v = 1'b0;
                    end
                end
            end
            ST_WALK: begin
                if (out_free) begin
                    n_left = r_left - CNT_W'(1);
                    if (r_cmd == CMD_REMOVE) begin
                        // first match leaves the ring, the rest keeps rotating
                        if (!r_found && (head == r_val)) begin
                            cell_ctrl.op = CELL_DROP;
                            n_found      = 1'b1;
                            n_count      = r_count - CNT_W'(1);
                        end else begin
                            cell_ctrl.op = CELL_ROTATE;
                        end
                    end else begin
                        cell_ctrl.op = CELL_ROTATE;
                        if (head_pick) begin
                            // a later pick proves the held one is not last
                            if (r_pend_v) begin
                                emit  = 1'b1;
                                n_out = '{status: STS_ENTRY, entry_value: r_pend, last: 1'b0};
                            end
                            n_pend   = head;
                            n_pend_v = 1'b1;
                        end
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    if (r_cmd == CMD_REMOVE) begin
                        emit  = 1'b1;
                        n_out = '{status: (r_found ? STS_REMOVED : STS_NOT_FOUND),
                                  entry_value: '0, last: 1'b1};
                    end else if (r_pend_v) begin
                        emit  = 1'b1;
                        n_out = '{status: STS_ENTRY, entry_value: r_pend, last: 1'b1};
                    end
                    n_pend_v = 1'b0;
                end
            end
            default: begin
                cell_ctrl.op = CELL_HOLD;
            end
        endcase

        if (emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_left      <= '0;
            r_found     <= 1'b0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_left      <= n_left;
            r_found     <= n_found;
            r_pend_v    <= n_pend_v;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_val  <= n_val;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // fill level stays within the cell row
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    // an append with room grows the list by one entry
    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (i_in_word.command == CMD_APPEND) && !is_full)
        |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("append with room did not grow the list");

    // a walk never runs on an empty ring and never past the capacity
    a_walk_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> ((r_left != '0) && (r_left <= CNT_W'(CAPACITY))))
        else $error("walk counter out of range");

    // status words are always the final word of their command
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.status != STS_ENTRY)) |-> o_out_word.last)
        else $error("status word without last");

endmodule

// ===== dv/ovl_list_checker.sv =====
module ovl_list_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  ovl_pkg::t_in_word  i_in_word,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  ovl_pkg::t_out_word i_out_word,
    output int                 o_fail_count,
    output int                 o_pending
);
    import ovl_pkg::*;

    // shadow list, head at index 0
    logic signed [VAL_W-1:0] list_vals[$];
    t_out_word               due_words[$];
    int                      mismatch_count = 0;
    int                      words_due = 0;

    assign o_fail_count = mismatch_count;
    assign o_pending    = words_due;

    task automatic report_mismatch(input string msg);
        $display("%0t ovl mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic add_status_word(input t_status sts);
        t_out_word w;
        w.status      = sts;
        w.entry_value = '0;
        w.last        = 1'b1;
        due_words.push_back(w);
    endtask

    task automatic apply_list_command(input t_in_word cmd_word);
        logic signed [VAL_W-1:0] shown[$];
        t_out_word               w;
        int                      hit;
        hit = -1;
        case (t_cmd'(cmd_word.command))
            CMD_APPEND: begin
                if (list_vals.size() >= CAPACITY) add_status_word(STS_FULL);
                else list_vals.push_back(cmd_word.operand_value);
            end
            CMD_REMOVE: begin
                if (list_vals.size() == 0) begin
                    add_status_word(STS_EMPTY);
                end else begin
                    foreach (list_vals[i]) begin
                        if (hit < 0 && list_vals[i] == cmd_word.operand_value) hit = i;
                    end
                    if (hit < 0) begin
                        add_status_word(STS_NOT_FOUND);
                    end else begin
                        list_vals.delete(hit);
                        add_status_word(STS_REMOVED);
                    end
                end
            end
            default: begin
                if (list_vals.size() == 0) begin
                    add_status_word(STS_EMPTY);
                end else begin
                    // even test is on bit 0, so negatives work too
                    foreach (list_vals[i]) begin
                        if (cmd_word.command == CMD_LIST_ALL || !list_vals[i][0]) begin
                            shown.push_back(list_vals[i]);
                        end
                    end
                    foreach (shown[i]) begin
                        w.status      = STS_ENTRY;
                        w.entry_value = shown[i];
                        w.last        = (i == shown.size() - 1);
                        due_words.push_back(w);
                    end
                end
            end
        endcase
    endtask

    task automatic check_out_word(input t_out_word got);
        t_out_word want;
        if (due_words.size() == 0) begin
            report_mismatch($sformatf("unexpected word status=%0d value=%0d last=%0b",
                                      got.status, got.entry_value, got.last));
        end else begin
            want = due_words.pop_front();
            if (got.status !== want.status) begin
                report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
            end
            if (got.entry_value !== want.entry_value) begin
                report_mismatch($sformatf("entry_value %0d, want %0d",
                                          got.entry_value, want.entry_value));
            end
            if (got.last !== want.last) begin
                report_mismatch($sformatf("last %b, want %b", got.last, want.last));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            list_vals.delete();
            due_words.delete();
        end else begin
            if (i_in_valid && i_in_ready) apply_list_command(i_in_word);
            if (i_out_valid && i_out_ready) check_out_word(i_out_word);
        end
        words_due = due_words.size();
    end

endmodule

// ===== dv/tb.sv =====
module tb;
    import ovl_pkg::*;

    // clock, reset and both channels of the block
    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_word  in_word;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_word out_word;

    // verdict inputs from the checker
    int fail_count;
    int pending;

    // idling controls, written at a rising edge and read at the next falling edge
    bit tx_idle_on = 1'b0;
    bit rx_idle_on = 1'b0;
    int stall_req  = 0;
    int stall_left = 0;
    int rx_gap     = 0;

    // recently appended values, so removes usually find a match
    logic signed [VAL_W-1:0] appended_vals[$];

    ordered_value_list_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    ovl_list_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_word   (out_word),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #8_000_000;
        $display("ordered_value_list_unit regression: fail");
        $finish;
    end

    // receiver: a long hold-off when asked, otherwise short random stalls
    always @(negedge clk) begin
        if (stall_req > 0) begin
            stall_left = stall_req;
            stall_req  = 0;
        end
        if (stall_left > 0) begin
            out_ready <= 1'b0;
            stall_left--;
        end else if (rx_gap > 0) begin
            out_ready <= 1'b0;
            rx_gap--;
        end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
            out_ready <= 1'b0;
            rx_gap = $urandom_range(1, 3) - 1;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // a third small values for duplicates and hits, some extremes, half full range
    function automatic logic signed [VAL_W-1:0] rand_value();
        logic signed [VAL_W-1:0] v;
        case ($urandom_range(0, 5))
            0, 1: v = $signed($urandom_range(0, 16)) - 8;
            2: begin
                case ($urandom_range(0, 3))
                    0:       v = 32'sh7fff_ffff;
                    1:       v = 32'sh8000_0000;
                    2:       v = '0;
                    default: v = '1;
                endcase
            end
            default: v = $urandom();
        endcase
        return v;
    endfunction

    function automatic logic signed [VAL_W-1:0] remove_value();
        if (appended_vals.size() > 0 && $urandom_range(0, 9) < 7) begin
            return appended_vals[$urandom_range(0, appended_vals.size() - 1)];
        end
        return rand_value();
    endfunction

    function automatic t_cmd pick_cmd(input int append_pct, input int remove_pct,
                                      input int list_all_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < append_pct) return CMD_APPEND;
        if (r < append_pct + remove_pct) return CMD_REMOVE;
        if (r < append_pct + remove_pct + list_all_pct) return CMD_LIST_ALL;
        return CMD_LIST_EVEN;
    endfunction

    // offer one word from a falling edge, hold it until taken, return at a falling edge
    task automatic send_word(input t_cmd cmd, input logic signed [VAL_W-1:0] val);
        int gap;
        gap = 0;
        if (tx_idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 3);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= '{command: cmd, operand_value: val};
        do @(posedge clk); while (!in_ready);
        if (cmd == CMD_APPEND) begin
            appended_vals.push_back(val);
            if (appended_vals.size() > 32) void'(appended_vals.pop_front());
        end
        @(negedge clk);
    endtask

    // random command mix; list commands get a random, ignored operand
    task automatic run_mix(input int n, input int append_pct, input int remove_pct,
                           input int list_all_pct);
        t_cmd                    cmd;
        logic signed [VAL_W-1:0] val;
        repeat (n) begin
            cmd = pick_cmd(append_pct, remove_pct, list_all_pct);
            case (cmd)
                CMD_APPEND: val = rand_value();
                CMD_REMOVE: val = remove_value();
                default:    val = $urandom();
            endcase
            send_word(cmd, val);
        end
    endtask

    // sender goes quiet until every expected word has come back
    task automatic pause_until_drained();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic set_idling(input bit tx_on, input bit rx_on);
        @(posedge clk);
        tx_idle_on = tx_on;
        rx_idle_on = rx_on;
        @(negedge clk);
    endtask

    initial begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_word  = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        set_idling(1'b1, 1'b1);

        // directed: empty list on list all, list even and remove
        send_word(CMD_LIST_ALL, $urandom());
        send_word(CMD_LIST_EVEN, $urandom());
        send_word(CMD_REMOVE, 32'sd5);
        // odd-only list: list even gives nothing
        send_word(CMD_APPEND, 32'sh7fff_ffff);
        send_word(CMD_APPEND, -32'sd1);
        send_word(CMD_LIST_EVEN, $urandom());
        send_word(CMD_LIST_ALL, $urandom());
        // negative evens, zero and a duplicate
        send_word(CMD_APPEND, 32'sh8000_0000);
        send_word(CMD_APPEND, -32'sd2);
        send_word(CMD_APPEND, 32'sd0);
        send_word(CMD_APPEND, -32'sd1);
        send_word(CMD_LIST_EVEN, $urandom());
        // miss, then first of two matches goes, order kept
        send_word(CMD_REMOVE, 32'sd12345);
        send_word(CMD_REMOVE, -32'sd1);
        send_word(CMD_LIST_ALL, $urandom());
        send_word(CMD_REMOVE, 32'sh8000_0000);
        send_word(CMD_REMOVE, 32'sh7fff_ffff);
        send_word(CMD_REMOVE, 32'sd0);
        send_word(CMD_LIST_EVEN, $urandom());
        send_word(CMD_REMOVE, -32'sd2);
        send_word(CMD_REMOVE, -32'sd1);
        // back to empty
        send_word(CMD_LIST_EVEN, $urandom());
        send_word(CMD_REMOVE, -32'sd1);
        pause_until_drained();

        // balanced mix with idling on both sides
        run_mix(50, 45, 25, 15);
        pause_until_drained();

        // receiver holds off a long time while list commands keep coming,
        // so the output backs up and the input stalls
        @(posedge clk);
        stall_req = 200;
        @(negedge clk);
        run_mix(30, 30, 10, 40);
        pause_until_drained();

        // fill to capacity, then at least two appends against a full store
        repeat (CAPACITY + 2) send_word(CMD_APPEND, rand_value());
        send_word(CMD_LIST_ALL, $urandom());
        send_word(CMD_LIST_EVEN, $urandom());
        pause_until_drained();

        // remove-heavy, sender idles only
        set_idling(1'b1, 1'b0);
        run_mix(70, 30, 50, 10);
        pause_until_drained();

        // append-heavy, runs into full again, receiver idles only
        set_idling(1'b0, 1'b1);
        run_mix(70, 80, 8, 6);
        pause_until_drained();

        // balanced, sender idles only
        set_idling(1'b1, 1'b0);
        run_mix(50, 40, 30, 15);
        pause_until_drained();

        // last stretch at full rate, no idling anywhere
        set_idling(1'b0, 1'b0);
        run_mix(60, 40, 30, 15);
        pause_until_drained();

        // a silent command may still be walking the list
        repeat (2 * CAPACITY + 16) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("ordered_value_list_unit regression: pass");
        end else begin
            $display("ordered_value_list_unit regression: fail");
        end
        $finish;
    end

endmodule
